// ----- design/abpd_pkg.sv -----
`default_nettype none

package abpd_pkg;

    // beta weights are Q1.8, 256 means one
    localparam int                    BETA_BITS  = 9;
    localparam int                    BETA_SHIFT = 8;
    localparam logic [BETA_BITS-1:0]  BETA_ONE   = 9'd256;
    localparam logic [BETA_BITS-1:0]  BETA_RESET = 9'd128;

    // integer part of the per-sample drop of the maximum level
    localparam int                    DECAY_INT  = 10;

    // reset value of the silence limit, integer sample units
    localparam int                    SILENCE_RESET = 20;

    // configuration register indexes
    localparam int                    CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DC_OFFSET     = 2'd0,
        CFG_SILENCE_LIMIT = 2'd1,
        CFG_AVERAGE_BETA  = 2'd2,
        CFG_SIGNAL_BETA   = 2'd3
    } t_cfg_index;

endpackage

`default_nettype wire

// ----- design/audio_beat_peak_detector.sv -----
`default_nettype none

// audio beat peak detector
//
// slave stream: one raw unsigned adc sample per transaction in the low bits of
// i_s_axis_tdata. master stream: one result per sample, with the gated signal,
// the decaying maximum and the running average in o_m_axis_tdata and the beat
// flag in o_m_axis_tuser. levels are unsigned Q(SAMPLE_BITS).(FRACTION_BITS).
// configuration: write channel i_cfg_valid / o_cfg_ready with a register index
// and data; o_cfg_ready is always high. write only while the block is idle.
// a sample passes through two register stages, sample and result; it leaves the
// sample register for the result register when the result register is free.
// throughput: one sample per cycle while the receiver keeps up; the whole update
// of the five state levels is one pass of logic from the sample register to the result register.
// when the receiver stalls, the result register holds and the sample register
// still fills, so one more sample is taken before o_s_axis_tready drops.
// reset (synchronous, active low) zeroes both valid flags and the level state,
// and loads the register defaults: offset 0, silence limit 20, betas 128 (one half).

module audio_beat_peak_detector #(
    parameter  int SAMPLE_BITS   = 10,
    parameter  int FRACTION_BITS = 8,
    localparam int LEVEL_W       = SAMPLE_BITS + FRACTION_BITS,
    localparam int IN_DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W    = ((3 * LEVEL_W + 7) / 8) * 8,
    localparam int CFG_DATA_W    = (SAMPLE_BITS > abpd_pkg::BETA_BITS)
                                   ? SAMPLE_BITS : abpd_pkg::BETA_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [abpd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]               i_cfg_data,

    // sample stream in
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: raw_sample, zero padded
    input  wire logic [IN_DATA_W-1:0]                i_s_axis_tdata,

    // result stream out
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata: signal_level, max_level, average_level, zero padded
    output logic [OUT_DATA_W-1:0]                    o_m_axis_tdata,
    // tuser: peak_flag
    output logic                                     o_m_axis_tuser
);

    localparam int                 BB      = abpd_pkg::BETA_BITS;
    localparam int                 ACC_W   = LEVEL_W + BB;
    localparam logic [LEVEL_W-1:0] DECAY_STEP =
        LEVEL_W'(abpd_pkg::DECAY_INT) << FRACTION_BITS;

    // new * beta + old * (one - beta), truncated back to a level
    function automatic logic [LEVEL_W-1:0] blend(
        input logic [LEVEL_W-1:0] fresh,
        input logic [LEVEL_W-1:0] old,
        input logic [BB-1:0]      beta
    );
        logic [BB-1:0]    b;
        logic [ACC_W-1:0] acc;
        b   = (beta > abpd_pkg::BETA_ONE) ? abpd_pkg::BETA_ONE : beta;
        acc = (ACC_W'(fresh) * ACC_W'(b))
            + (ACC_W'(old) * ACC_W'(abpd_pkg::BETA_ONE - b));
        return acc[abpd_pkg::BETA_SHIFT +: LEVEL_W];
    endfunction

    // configuration registers
    logic [SAMPLE_BITS-1:0] r_dc_offset;
    logic [SAMPLE_BITS-1:0] r_silence_limit;
    logic [BB-1:0]          r_average_beta;
    logic [BB-1:0]          r_signal_beta;

    // sample stage
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;

    // level state
    logic [LEVEL_W-1:0]     r_running_average;
    logic [LEVEL_W-1:0]     r_filtered_signal;
    logic [LEVEL_W-1:0]     r_previous_signal;
    logic [LEVEL_W-1:0]     r_decaying_maximum;
    logic [LEVEL_W-1:0]     r_average_peak_step;

    // result stage
    logic                   r_out_valid;
    logic                   r_out_peak;
    logic [LEVEL_W-1:0]     r_out_signal;
    logic [LEVEL_W-1:0]     r_out_max;
    logic [LEVEL_W-1:0]     r_out_average;

    // next values
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [LEVEL_W-1:0]     w_magq;
    logic                   w_gate;
    logic [LEVEL_W-1:0]     n_running_average;
    logic [LEVEL_W-1:0]     n_filtered_signal;
    logic [LEVEL_W-1:0]     w_decayed;
    logic [LEVEL_W-1:0]     n_decaying_maximum;
    logic [LEVEL_W-1:0]     w_rise;
    logic [LEVEL_W:0]       w_step_sum;
    logic [LEVEL_W-1:0]     n_average_peak_step;
    logic                   n_peak;

    logic                   w_out_free;
    logic                   w_advance;

    // result register frees when empty or taken this cycle
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign o_cfg_ready     = 1'b1;

    // single pass level update
    always_comb begin
        w_mag  = (r_in_sample >= r_dc_offset) ? (r_in_sample - r_dc_offset)
                                              : (r_dc_offset - r_in_sample);
        w_magq = LEVEL_W'(w_mag) << FRACTION_BITS;

        n_running_average = blend(w_magq, r_running_average, r_average_beta);

        // below half the average or below the silence limit: no signal
        w_gate = ({w_magq, 1'b0} < (LEVEL_W + 1)'(n_running_average))
              || (w_mag < r_silence_limit);
        n_filtered_signal = w_gate ? '0
                          : blend(w_magq, r_filtered_signal, r_signal_beta);

        w_decayed = (r_decaying_maximum < DECAY_STEP) ? '0
                  : (r_decaying_maximum - DECAY_STEP);
        n_decaying_maximum = (w_decayed < n_filtered_signal) ? n_filtered_signal
                                                             : w_decayed;

        w_rise     = n_filtered_signal - r_previous_signal;
        w_step_sum = (LEVEL_W + 1)'(r_average_peak_step) + (LEVEL_W + 1)'(w_rise);
        // sharp rise: signal above average above previous signal
        if ((n_filtered_signal > n_running_average)
                && (n_running_average > r_previous_signal)) begin
            n_average_peak_step = w_step_sum[LEVEL_W:1];
        end else begin
            n_average_peak_step = r_average_peak_step;
        end

        n_peak = (n_filtered_signal > r_previous_signal)
              && (w_rise > n_average_peak_step);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_offset     <= '0;
            r_silence_limit <= SAMPLE_BITS'(abpd_pkg::SILENCE_RESET);
            r_average_beta  <= abpd_pkg::BETA_RESET;
            r_signal_beta   <= abpd_pkg::BETA_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                abpd_pkg::CFG_DC_OFFSET:     r_dc_offset     <= i_cfg_data[SAMPLE_BITS-1:0];
                abpd_pkg::CFG_SILENCE_LIMIT: r_silence_limit <= i_cfg_data[SAMPLE_BITS-1:0];
                abpd_pkg::CFG_AVERAGE_BETA:  r_average_beta  <= i_cfg_data[BB-1:0];
                abpd_pkg::CFG_SIGNAL_BETA:   r_signal_beta   <= i_cfg_data[BB-1:0];
                default: begin
                end
            endcase
        end
    end

    // sample stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_sample <= i_s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // level state, updated once per sample moved into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_average   <= '0;
            r_filtered_signal   <= '0;
            r_previous_signal   <= '0;
            r_decaying_maximum  <= '0;
            r_average_peak_step <= '0;
        end else if (w_advance) begin
            r_running_average   <= n_running_average;
            r_filtered_signal   <= n_filtered_signal;
            r_previous_signal   <= n_filtered_signal;
            r_decaying_maximum  <= n_decaying_maximum;
            r_average_peak_step <= n_average_peak_step;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_peak    <= n_peak;
            r_out_signal  <= n_filtered_signal;
            r_out_max     <= n_decaying_maximum;
            r_out_average <= n_running_average;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_peak;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_average, r_out_max, r_out_signal});

    // state only moves when a sample passes to the result stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_running_average) && $stable(r_decaying_maximum))
        else $error("level state changed without a sample");

    // a beat needs a nonzero signal
    a_peak_signal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_peak |-> r_out_signal != '0)
        else $error("beat flagged with zero signal");

    // the maximum is never below the signal it was raised to
    a_max_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_max >= r_out_signal)
        else $error("maximum below signal");

    // previous signal tracks the last delivered signal
    a_prev_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_previous_signal == r_out_signal)
        else $error("previous signal out of step with result");

endmodule

`default_nettype wire
